FILE: rtl/core/stereo_feedback_delay_tone_macros.svh
// Assertion macros for the stereo feedback delay with tone filter.
// Taken in by the top level; needs nothing else.
`ifndef STEREO_FEEDBACK_DELAY_TONE_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_TONE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset
`define SFDT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset
`define SFDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/sfdt_pkg.sv
// Shared types and constants of the stereo feedback delay with tone filter.
// Used by sfdt_mac and stereo_feedback_delay_tone; depends on nothing.
package sfdt_pkg;

   // Register field widths
   localparam int DELAY_W    = 15;
   localparam int WET_W      = 17;
   localparam int DRY_W      = 18;
   localparam int FB_W       = 15;
   localparam int LP_W       = 16;
   localparam int LMIX_W     = 18;
   localparam int HMIX_W     = 17;

   // Signed coefficient width at the multiplier, and accumulator guard bits
   localparam int COEF_W     = 19;
   localparam int ACC_GUARD  = 22;

   // Shortest tap distance
   localparam int MIN_DELAY  = 4;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_DELAY_LEFT    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_DELAY_RIGHT   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_WET_GAIN      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DRY_GAIN      = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_LOWPASS_COEF  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_LOW_MIX       = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_HIGH_MIX      = 3'd7;

   // Register reset values
   localparam logic [DELAY_W-1:0] DELAY_LEFT_RST    = 15'd8191;
   localparam logic [DELAY_W-1:0] DELAY_RIGHT_RST   = 15'd8846;
   localparam logic [WET_W-1:0]   WET_GAIN_RST      = 17'd18060;
   localparam logic [DRY_W-1:0]   DRY_GAIN_RST      = 18'd58400;
   localparam logic [FB_W-1:0]    FEEDBACK_GAIN_RST = 15'd22708;
   localparam logic [LP_W-1:0]    LOWPASS_COEF_RST  = 16'd1180;
   localparam logic [LMIX_W-1:0]  LOW_MIX_RST       = 18'd0;
   localparam logic [HMIX_W-1:0]  HIGH_MIX_RST      = 17'd65536;

   // Control of one multiply-accumulate operation
   typedef struct packed {
      logic                     issue;  // start an operation this cycle
      logic                     first;  // restart the accumulator
      logic                     sub;    // operand is x - y instead of x + y
      logic signed [COEF_W-1:0] coef;
   } mac_ctl_type;

endpackage

FILE: rtl/core/sfdt_mac.sv
// Shared multiply-accumulate unit: pre-add, multiply, accumulate, round.
// Depends on sfdt_pkg for the control struct and coefficient width.
module sfdt_mac #(
   parameter int SAMPLE_WIDTH   = 24,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  sfdt_pkg::mac_ctl_type                             ctl,
   input  logic signed [SAMPLE_WIDTH-1:0]                    x,
   input  logic signed [SAMPLE_WIDTH-1:0]                    y,
   output logic signed [SAMPLE_WIDTH+sfdt_pkg::ACC_GUARD-1:0] rnd
);

   localparam int SUM_W  = SAMPLE_WIDTH + 1;
   localparam int PROD_W = SUM_W + sfdt_pkg::COEF_W;
   localparam int ACC_W  = SAMPLE_WIDTH + sfdt_pkg::ACC_GUARD;

   // Rounding offset: half an LSB of the result, preloaded into the accumulator
   localparam logic signed [ACC_W-1:0] HALF =
      {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

   logic                               v0_ff, v1_ff;
   logic                               first0_ff, first1_ff;
   logic signed [SUM_W-1:0]            sum_ff;
   logic signed [sfdt_pkg::COEF_W-1:0] coef_ff;
   logic signed [PROD_W-1:0]           prod_ff;
   logic signed [ACC_W-1:0]            acc_ff;
   logic signed [SUM_W-1:0]            sum_in;

   // Pre-add stage operand
   always_comb begin
      if (ctl.sub) begin
         sum_in = SUM_W'(x) - SUM_W'(y);
      end else begin
         sum_in = SUM_W'(x) + SUM_W'(y);
      end
   end

   // Advance the operation flags through the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= ctl.issue;
         v1_ff <= v0_ff;
      end
   end

   // Pre-add, multiply and accumulate
   always_ff @(posedge clock) begin
      first0_ff <= ctl.first;
      sum_ff    <= sum_in;
      coef_ff   <= ctl.coef;
      first1_ff <= first0_ff;
      prod_ff   <= coef_ff * sum_ff;
      if (v1_ff) begin
         if (first1_ff) begin
            acc_ff <= HALF + ACC_W'(prod_ff);
         end else begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   // Floor after the half offset gives round half up
   assign rnd = acc_ff >>> COEF_FRAC_BITS;

endmodule

FILE: rtl/core/stereo_feedback_delay_tone.sv
// Stereo feedback delay with a one-pole tone filter in the feedback path.
// Depends on sfdt_pkg, sfdt_mac and stereo_feedback_delay_tone_macros.svh.
//
// Usage:
//   req_* stream: one beat is a stereo sample pair, taken while the block is idle.
//   rsp_* stream: one beat per accepted pair, the left and right outputs.
//   csr_* port: eight registers at byte address 4*i, written while idle.
// Timing: a pair is accepted in an idle cycle and its result shows on rsp_tvalid
//   when the sequencer leaves S_OUT; the block is idle again in that same cycle,
//   so it takes no new pair while one is in work. The pace is set by seven
//   products through the one shared three-stage multiply-accumulate unit, with
//   two sequential tap reads through the one read port of the delay memory.
// Stall: the result waits in the output register; the block takes the next pair
//   and works on it, and holds that result until the output register frees.
// Reset: registers return to their defaults, the write pointer, filter state and
//   fill count clear. The delay memory is not swept: a fill count of pairs seen
//   since reset marks taps that reach unwritten entries, and those read as zero.
`include "stereo_feedback_delay_tone_macros.svh"

module stereo_feedback_delay_tone #(
   parameter int BUFFER_DEPTH   = 32768,
   parameter int SAMPLE_WIDTH   = 24,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Input stream
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      req_tdata,  // left_in, right_in
   // Result stream
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      rsp_tdata,  // left_out, right_out
   // Configuration port
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [sfdt_pkg::CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [sfdt_pkg::CSR_DATA_W-1:0]          csr_pwdata,
   output logic [sfdt_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                     csr_pready
);

   localparam int SW      = SAMPLE_WIDTH;
   localparam int ACC_W   = SW + sfdt_pkg::ACC_GUARD;
   localparam int SUM_W   = ACC_W + 1;
   localparam int ADDR_W  = $clog2(BUFFER_DEPTH);
   localparam int CNT_W   = ADDR_W + 1;
   localparam int CMP_W   = ((ADDR_W > sfdt_pkg::DELAY_W) ? ADDR_W : sfdt_pkg::DELAY_W) + 1;
   localparam int TDATA_W = ((2*SAMPLE_WIDTH+7)/8)*8;
   localparam int CW      = sfdt_pkg::COEF_W;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BUFFER_DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(BUFFER_DEPTH);
   localparam logic [CMP_W-1:0]  CMP_LAST  = CMP_W'(BUFFER_DEPTH - 1);
   localparam logic [CMP_W-1:0]  CMP_MIN   = CMP_W'(sfdt_pkg::MIN_DELAY);

   localparam logic signed [SUM_W-1:0] SMAX =
      {{(SUM_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SMIN =
      {{(SUM_W-SW+1){1'b1}}, {(SW-1){1'b0}}};

   // Sequencer states
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_RDL  = 5'd1;
   localparam logic [4:0] S_RDR  = 5'd2;
   localparam logic [4:0] S_WET  = 5'd3;
   localparam logic [4:0] S_FB   = 5'd4;
   localparam logic [4:0] S_W1   = 5'd5;
   localparam logic [4:0] S_W2   = 5'd6;
   localparam logic [4:0] S_MIX  = 5'd7;
   localparam logic [4:0] S_LP   = 5'd8;
   localparam logic [4:0] S_W3   = 5'd9;
   localparam logic [4:0] S_W4   = 5'd10;
   localparam logic [4:0] S_FS   = 5'd11;
   localparam logic [4:0] S_LM   = 5'd12;
   localparam logic [4:0] S_HM   = 5'd13;
   localparam logic [4:0] S_W5   = 5'd14;
   localparam logic [4:0] S_W6   = 5'd15;
   localparam logic [4:0] S_ST   = 5'd16;
   localparam logic [4:0] S_OUT  = 5'd17;

   function automatic logic signed [SW-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
      logic signed [SW-1:0] r;
      if (v > SMAX) begin
         r = SMAX[SW-1:0];
      end else if (v < SMIN) begin
         r = SMIN[SW-1:0];
      end else begin
         r = v[SW-1:0];
      end
      return r;
   endfunction

   // Configuration registers
   logic [sfdt_pkg::DELAY_W-1:0] delay_left_ff, delay_right_ff;
   logic [sfdt_pkg::WET_W-1:0]   wet_gain_ff;
   logic [sfdt_pkg::DRY_W-1:0]   dry_gain_ff;
   logic [sfdt_pkg::FB_W-1:0]    feedback_gain_ff;
   logic [sfdt_pkg::LP_W-1:0]    lowpass_coef_ff;
   logic [sfdt_pkg::LMIX_W-1:0]  low_mix_ff;
   logic [sfdt_pkg::HMIX_W-1:0]  high_mix_ff;

   logic                           csr_wr;
   logic [sfdt_pkg::REG_IDX_W-1:0] csr_idx;

   // Control state
   logic [4:0]        state_ff, state_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic signed [SW-1:0] fs_ff, fs_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload
   logic signed [SW-1:0]    a_ff, b_ff, tl_ff, tr_ff, mix_ff;
   logic signed [SW-1:0]    left_ff, right_ff;
   logic signed [ACC_W-1:0] da_ff, db_ff;
   logic [SW-1:0]           rd_data_ff;
   logic                    tap_ok_ff;
   logic signed [SW-1:0]    tap_value;

   // Tap address
   logic [sfdt_pkg::DELAY_W-1:0] tap_raw;
   logic [CMP_W-1:0]             tap_ext, tap_clamp;
   logic [ADDR_W-1:0]            tap_dist, tap_addr;
   logic [CNT_W-1:0]             tap_sum, tap_wrap;
   logic                         tap_ok_in;

   // Delay memory
   logic [SW-1:0] store_mem [BUFFER_DEPTH];
   logic          store_we;
   logic [SW-1:0] store_wd;

   // Shared multiply-accumulate unit
   sfdt_pkg::mac_ctl_type   mac_ctl;
   logic signed [SW-1:0]    mac_x, mac_y;
   logic signed [ACC_W-1:0] mac_rnd;
   logic signed [CW-1:0]    wet_coef, dry_coef, fb_coef, lp_coef, lm_coef, hm_coef;

   logic req_fire, out_load;
   logic signed [SW-1:0] rnd_sat, fs_sat, left_sat, right_sat;

   // Configuration port: writes land in the access phase, reads are direct
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[sfdt_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_left_ff    <= sfdt_pkg::DELAY_LEFT_RST;
         delay_right_ff   <= sfdt_pkg::DELAY_RIGHT_RST;
         wet_gain_ff      <= sfdt_pkg::WET_GAIN_RST;
         dry_gain_ff      <= sfdt_pkg::DRY_GAIN_RST;
         feedback_gain_ff <= sfdt_pkg::FEEDBACK_GAIN_RST;
         lowpass_coef_ff  <= sfdt_pkg::LOWPASS_COEF_RST;
         low_mix_ff       <= sfdt_pkg::LOW_MIX_RST;
         high_mix_ff      <= sfdt_pkg::HIGH_MIX_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            sfdt_pkg::REG_DELAY_LEFT:    delay_left_ff    <= csr_pwdata[sfdt_pkg::DELAY_W-1:0];
            sfdt_pkg::REG_DELAY_RIGHT:   delay_right_ff   <= csr_pwdata[sfdt_pkg::DELAY_W-1:0];
            sfdt_pkg::REG_WET_GAIN:      wet_gain_ff      <= csr_pwdata[sfdt_pkg::WET_W-1:0];
            sfdt_pkg::REG_DRY_GAIN:      dry_gain_ff      <= csr_pwdata[sfdt_pkg::DRY_W-1:0];
            sfdt_pkg::REG_FEEDBACK_GAIN: feedback_gain_ff <= csr_pwdata[sfdt_pkg::FB_W-1:0];
            sfdt_pkg::REG_LOWPASS_COEF:  lowpass_coef_ff  <= csr_pwdata[sfdt_pkg::LP_W-1:0];
            sfdt_pkg::REG_LOW_MIX:       low_mix_ff       <= csr_pwdata[sfdt_pkg::LMIX_W-1:0];
            sfdt_pkg::REG_HIGH_MIX:      high_mix_ff      <= csr_pwdata[sfdt_pkg::HMIX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         sfdt_pkg::REG_DELAY_LEFT:    csr_prdata = sfdt_pkg::CSR_DATA_W'(delay_left_ff);
         sfdt_pkg::REG_DELAY_RIGHT:   csr_prdata = sfdt_pkg::CSR_DATA_W'(delay_right_ff);
         sfdt_pkg::REG_WET_GAIN:      csr_prdata = sfdt_pkg::CSR_DATA_W'(wet_gain_ff);
         sfdt_pkg::REG_DRY_GAIN:      csr_prdata = sfdt_pkg::CSR_DATA_W'(dry_gain_ff);
         sfdt_pkg::REG_FEEDBACK_GAIN: csr_prdata = sfdt_pkg::CSR_DATA_W'(feedback_gain_ff);
         sfdt_pkg::REG_LOWPASS_COEF:  csr_prdata = sfdt_pkg::CSR_DATA_W'(lowpass_coef_ff);
         sfdt_pkg::REG_LOW_MIX:       csr_prdata = sfdt_pkg::CSR_DATA_W'(low_mix_ff);
         sfdt_pkg::REG_HIGH_MIX:      csr_prdata = sfdt_pkg::CSR_DATA_W'(high_mix_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // Coefficients widened to the signed multiplier operand
   assign wet_coef = {{(CW-sfdt_pkg::WET_W){1'b0}}, wet_gain_ff};
   assign dry_coef = {{(CW-sfdt_pkg::DRY_W){1'b0}}, dry_gain_ff};
   assign fb_coef  = {{(CW-sfdt_pkg::FB_W){1'b0}}, feedback_gain_ff};
   assign lp_coef  = {{(CW-sfdt_pkg::LP_W){1'b0}}, lowpass_coef_ff};
   assign lm_coef  = {{(CW-sfdt_pkg::LMIX_W){low_mix_ff[sfdt_pkg::LMIX_W-1]}}, low_mix_ff};
   assign hm_coef  = {{(CW-sfdt_pkg::HMIX_W){1'b0}}, high_mix_ff};

   // Tap address: clamp the distance, add to the write pointer, wrap once
   always_comb begin
      tap_raw = (state_ff == S_RDL) ? delay_left_ff : delay_right_ff;
      tap_ext = CMP_W'(tap_raw);
      if (tap_ext < CMP_MIN) begin
         tap_clamp = CMP_MIN;
      end else if (tap_ext > CMP_LAST) begin
         tap_clamp = CMP_LAST;
      end else begin
         tap_clamp = tap_ext;
      end
      tap_dist = tap_clamp[ADDR_W-1:0];
      tap_sum  = {1'b0, wp_ff} + {1'b0, tap_dist};
      tap_wrap = tap_sum - FULL_CNT;
      tap_addr = (tap_sum >= FULL_CNT) ? tap_wrap[ADDR_W-1:0] : tap_sum[ADDR_W-1:0];
      // The pair written d beats back reached this entry only if d beats were seen
      tap_ok_in = (cnt_ff >= {1'b0, tap_dist});
   end

   // Delay memory: one write port, one registered read port
   assign store_we = (state_ff == S_ST);
   assign store_wd = rnd_sat;

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[wp_ff] <= store_wd;
      end
      rd_data_ff <= store_mem[tap_addr];
      tap_ok_ff  <= tap_ok_in;
   end

   assign tap_value = tap_ok_ff ? $signed(rd_data_ff) : '0;

   // Operation schedule of the shared unit
   always_comb begin
      mac_ctl = '0;
      mac_x   = '0;
      mac_y   = '0;
      case (state_ff)
         S_RDL: begin
            mac_ctl.issue = 1'b1;
            mac_ctl.first = 1'b1;
            mac_ctl.coef  = dry_coef;
            mac_x         = a_ff;
         end
         S_RDR: begin
            mac_ctl.issue = 1'b1;
            mac_ctl.first = 1'b1;
            mac_ctl.coef  = dry_coef;
            mac_x         = b_ff;
         end
         S_WET: begin
            mac_ctl.issue = 1'b1;
            mac_ctl.first = 1'b1;
            mac_ctl.coef  = wet_coef;
            mac_x         = a_ff;
            mac_y         = b_ff;
         end
         S_FB: begin
            mac_ctl.issue = 1'b1;
            mac_ctl.coef  = fb_coef;
            mac_x         = tl_ff;
            mac_y         = tr_ff;
         end
         S_LP: begin
            mac_ctl.issue = 1'b1;
            mac_ctl.first = 1'b1;
            mac_ctl.sub   = 1'b1;
            mac_ctl.coef  = lp_coef;
            mac_x         = fs_ff;
            mac_y         = mix_ff;
         end
         S_LM: begin
            mac_ctl.issue = 1'b1;
            mac_ctl.first = 1'b1;
            mac_ctl.coef  = lm_coef;
            mac_x         = fs_ff;
         end
         S_HM: begin
            mac_ctl.issue = 1'b1;
            mac_ctl.coef  = hm_coef;
            mac_x         = mix_ff;
         end
         default: ;
      endcase
   end

   sfdt_mac #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .x     (mac_x),
      .y     (mac_y),
      .rnd   (mac_rnd)
   );

   // Saturated views of the rounded accumulator
   assign rnd_sat   = sat_sample(SUM_W'(mac_rnd));
   assign fs_sat    = sat_sample(SUM_W'(mix_ff) + SUM_W'(mac_rnd));
   assign left_sat  = sat_sample(SUM_W'(da_ff) + SUM_W'(tl_ff));
   assign right_sat = sat_sample(SUM_W'(db_ff) + SUM_W'(tr_ff));

   // Handshakes
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'({right_ff, left_ff});

   // Sequencer and loop state
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      cnt_in       = cnt_ff;
      fs_in        = fs_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_RDL;
            end
         end
         S_RDL: state_in = S_RDR;
         S_RDR: state_in = S_WET;
         S_WET: state_in = S_FB;
         S_FB:  state_in = S_W1;
         S_W1:  state_in = S_W2;
         S_W2:  state_in = S_MIX;
         S_MIX: state_in = S_LP;
         S_LP:  state_in = S_W3;
         S_W3:  state_in = S_W4;
         S_W4:  state_in = S_FS;
         S_FS: begin
            fs_in    = fs_sat;
            state_in = S_LM;
         end
         S_LM:  state_in = S_HM;
         S_HM:  state_in = S_W5;
         S_W5:  state_in = S_W6;
         S_W6:  state_in = S_ST;
         S_ST: begin
            // Step the pointer down and count the entry just written
            wp_in    = (wp_ff == '0) ? LAST_ADDR : wp_ff - 1'b1;
            cnt_in   = (cnt_ff == FULL_CNT) ? cnt_ff : cnt_ff + 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         fs_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         fs_ff        <= fs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture operands, taps and partial results as the schedule produces them
   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_ff <= req_tdata[SW-1:0];
         b_ff <= req_tdata[2*SW-1:SW];
      end
      if (state_ff == S_RDR) begin
         tl_ff <= tap_value;
      end
      if (state_ff == S_WET) begin
         tr_ff <= tap_value;
      end
      if (state_ff == S_FB) begin
         da_ff <= mac_rnd;
      end
      if (state_ff == S_W1) begin
         db_ff <= mac_rnd;
      end
      if (state_ff == S_MIX) begin
         mix_ff <= rnd_sat;
      end
      if (out_load) begin
         left_ff  <= left_sat;
         right_ff <= right_sat;
      end
   end

   // Checks
   `SFDT_ASSERT_NEXT(a_accept_read, clock, reset, req_fire, state_ff == S_RDL, "no tap read")
   `SFDT_ASSERT_NEXT(a_store_step, clock, reset, store_we, wp_ff != $past(wp_ff), "pointer held")
   `SFDT_ASSERT_IMPL(a_rsp_rise, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_OUT, "rise")
   `SFDT_ASSERT_IMPL(a_fill_bounded, clock, reset, 1'b1, cnt_ff <= FULL_CNT, "fill count past depth")

endmodule

FILE: bench/tb_stereo_feedback_delay_tone.sv
// Self-checking bench for stereo_feedback_delay_tone: stereo pairs in, echoed pairs out.
// Predicts each output pair in the bench, checks it beat by beat; needs sfdt_pkg and the RTL.
`timescale 1ns / 100ps

module tb_stereo_feedback_delay_tone;

   localparam int     DEPTH         = 32768;
   localparam int     CYCLE_LIMIT   = 500000;
   localparam int     SETTLE_CYCLES = 24;
   localparam int     LONG_STALL    = 400;
   localparam longint SAMPLE_MAX    = 64'sd8388607;
   localparam longint SAMPLE_MIN    = -64'sd8388608;

   localparam logic [23:0] FULL_POS  = 24'h7FFFFF;
   localparam logic [23:0] FULL_NEG  = 24'h800000;
   localparam logic [23:0] PLUS_ONE  = 24'h000001;
   localparam logic [23:0] MINUS_ONE = 24'hFFFFFF;

   typedef struct packed {
      logic [23:0] right;
      logic [23:0] left;
   } stereo_pair_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [47:0]                     req_tdata   = '0;  // left_in, right_in
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [47:0]                     rsp_tdata;         // left_out, right_out
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [sfdt_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [sfdt_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [sfdt_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // Bench copy of the echo state and of the registers
   logic signed [23:0]              echo_mem [DEPTH];
   int unsigned                     write_pos;
   longint                          tone_state;
   logic [sfdt_pkg::DELAY_W-1:0]    delay_left_q, delay_right_q;
   logic [sfdt_pkg::WET_W-1:0]      wet_gain_q;
   logic [sfdt_pkg::DRY_W-1:0]      dry_gain_q;
   logic [sfdt_pkg::FB_W-1:0]       feedback_gain_q;
   logic [sfdt_pkg::LP_W-1:0]       lowpass_q;
   logic [sfdt_pkg::LMIX_W-1:0]     low_mix_q;
   logic [sfdt_pkg::HMIX_W-1:0]     high_mix_q;

   logic [47:0]                     pair_queue[$];
   stereo_pair_type                 echo_expected[$];
   int                              fail_count    = 0;
   int                              send_idle_pct = 38;
   int                              recv_idle_pct = 61;
   logic                            send_hold     = 1'b0;
   logic                            stall_kick    = 1'b0;
   int                              stall_left    = 0;
   int                              cycle_count   = 0;

   stereo_feedback_delay_tone dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint clip_sample(input longint x);
      if (x > SAMPLE_MAX) return SAMPLE_MAX;
      if (x < SAMPLE_MIN) return SAMPLE_MIN;
      return x;
   endfunction

   // Drop 16 fraction bits, rounding half up
   function automatic longint q16_round(input longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   // Short distances act as the minimum; the register cannot exceed DEPTH - 1
   function automatic int unsigned tap_span(input logic [sfdt_pkg::DELAY_W-1:0] d);
      return (d < sfdt_pkg::MIN_DELAY) ? sfdt_pkg::MIN_DELAY : d;
   endfunction

   // Advance the echo state by one input pair and queue the pair it yields
   function automatic void predict_echo(input logic [47:0] beat);
      longint          l_in, r_in, tap_l, tap_r, loop_mix, stored, lmix, out_l, out_r;
      int unsigned     pos;
      stereo_pair_type next_pair;
      l_in     = longint'($signed(beat[23:0]));
      r_in     = longint'($signed(beat[47:24]));
      pos      = write_pos;
      tap_l    = longint'(echo_mem[(pos + tap_span(delay_left_q)) % DEPTH]);
      tap_r    = longint'(echo_mem[(pos + tap_span(delay_right_q)) % DEPTH]);
      lmix     = longint'($signed(low_mix_q));
      loop_mix = clip_sample(q16_round(longint'(wet_gain_q) * (l_in + r_in)
                                       + longint'(feedback_gain_q) * (tap_l + tap_r)));
      tone_state = clip_sample(loop_mix
                               + q16_round(longint'(lowpass_q) * (tone_state - loop_mix)));
      stored   = clip_sample(q16_round(lmix * tone_state + longint'(high_mix_q) * loop_mix));
      echo_mem[pos] = stored[23:0];
      write_pos = (pos == 0) ? DEPTH - 1 : pos - 1;
      out_l = clip_sample(q16_round(longint'(dry_gain_q) * l_in) + tap_l);
      out_r = clip_sample(q16_round(longint'(dry_gain_q) * r_in) + tap_r);
      next_pair.left  = out_l[23:0];
      next_pair.right = out_r[23:0];
      echo_expected.push_back(next_pair);
   endfunction

   function automatic void log_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t: %s", $time, msg);
   endfunction

   function automatic logic [23:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return FULL_POS;
         1:       return FULL_NEG;
         2, 3:    return 24'(int'($urandom_range(0, 2000)) - 1000);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic int unsigned random_delay();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 70);
   endfunction

   // Driver: hold a beat until taken, then offer the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         for (int i = 0; i < DEPTH; i++) echo_mem[i] = '0;
         write_pos       = 0;
         tone_state      = 0;
         delay_left_q    = sfdt_pkg::DELAY_LEFT_RST;
         delay_right_q   = sfdt_pkg::DELAY_RIGHT_RST;
         wet_gain_q      = sfdt_pkg::WET_GAIN_RST;
         dry_gain_q      = sfdt_pkg::DRY_GAIN_RST;
         feedback_gain_q = sfdt_pkg::FEEDBACK_GAIN_RST;
         lowpass_q       = sfdt_pkg::LOWPASS_COEF_RST;
         low_mix_q       = sfdt_pkg::LOW_MIX_RST;
         high_mix_q      = sfdt_pkg::HIGH_MIX_RST;
      end else begin
         if (req_tvalid && req_tready) predict_echo(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (pair_queue.size() != 0 && !send_hold
                && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pair_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result beat against the oldest expected pair
   always @(posedge clock) begin
      stereo_pair_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (echo_expected.size() == 0) begin
               log_failure($sformatf("result beat %h with no pair expected", rsp_tdata));
            end else begin
               want = echo_expected.pop_front();
               if (rsp_tdata[23:0] !== want.left)
                  log_failure($sformatf("left_out mismatch: expected %h, got %h",
                                        want.left, rsp_tdata[23:0]));
               if (rsp_tdata[47:24] !== want.right)
                  log_failure($sformatf("right_out mismatch: expected %h, got %h",
                                        want.right, rsp_tdata[47:24]));
            end
         end
         rsp_tready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Count down a long receiver hold-off when kicked
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
      end else if (stall_kick) begin
         stall_left <= LONG_STALL;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // Abort a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("stereo_feedback_delay_tone verification failed");
         $finish;
      end
   end

   // Write one register over the APB port, with junk above the field
   task automatic write_reg(input logic [sfdt_pkg::REG_IDX_W-1:0] idx,
                            input logic [31:0] value);
      int unsigned width;
      logic [31:0] keep;
      logic [31:0] word;
      case (idx)
         sfdt_pkg::REG_DELAY_LEFT,
         sfdt_pkg::REG_DELAY_RIGHT:   width = sfdt_pkg::DELAY_W;
         sfdt_pkg::REG_WET_GAIN:      width = sfdt_pkg::WET_W;
         sfdt_pkg::REG_DRY_GAIN:      width = sfdt_pkg::DRY_W;
         sfdt_pkg::REG_FEEDBACK_GAIN: width = sfdt_pkg::FB_W;
         sfdt_pkg::REG_LOWPASS_COEF:  width = sfdt_pkg::LP_W;
         sfdt_pkg::REG_LOW_MIX:       width = sfdt_pkg::LMIX_W;
         default:                     width = sfdt_pkg::HMIX_W;
      endcase
      keep = (32'd1 << width) - 32'd1;
      word = ($urandom & ~keep) | (value & keep);
      case (idx)
         sfdt_pkg::REG_DELAY_LEFT:    delay_left_q    = word[sfdt_pkg::DELAY_W-1:0];
         sfdt_pkg::REG_DELAY_RIGHT:   delay_right_q   = word[sfdt_pkg::DELAY_W-1:0];
         sfdt_pkg::REG_WET_GAIN:      wet_gain_q      = word[sfdt_pkg::WET_W-1:0];
         sfdt_pkg::REG_DRY_GAIN:      dry_gain_q      = word[sfdt_pkg::DRY_W-1:0];
         sfdt_pkg::REG_FEEDBACK_GAIN: feedback_gain_q = word[sfdt_pkg::FB_W-1:0];
         sfdt_pkg::REG_LOWPASS_COEF:  lowpass_q       = word[sfdt_pkg::LP_W-1:0];
         sfdt_pkg::REG_LOW_MIX:       low_mix_q       = word[sfdt_pkg::LMIX_W-1:0];
         default:                     high_mix_q      = word[sfdt_pkg::HMIX_W-1:0];
      endcase
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic apply_setting(input logic [31:0] dl, dr, wet, dry, fb, lp, lm, hm);
      write_reg(sfdt_pkg::REG_DELAY_LEFT, dl);
      write_reg(sfdt_pkg::REG_DELAY_RIGHT, dr);
      write_reg(sfdt_pkg::REG_WET_GAIN, wet);
      write_reg(sfdt_pkg::REG_DRY_GAIN, dry);
      write_reg(sfdt_pkg::REG_FEEDBACK_GAIN, fb);
      write_reg(sfdt_pkg::REG_LOWPASS_COEF, lp);
      write_reg(sfdt_pkg::REG_LOW_MIX, lm);
      write_reg(sfdt_pkg::REG_HIGH_MIX, hm);
   endtask

   task automatic random_setting();
      apply_setting(random_delay(), random_delay(), $urandom_range(0, 65536),
                    $urandom_range(0, 131072), $urandom_range(0, 32440),
                    $urandom_range(0, 65535), $urandom_range(0, 98304) - 32768,
                    $urandom_range(0, 65536));
   endtask

   // Wait until every pair is sent and answered, then let the block settle
   task automatic drain_all();
      while (pair_queue.size() != 0 || req_tvalid || echo_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_block(input int count, input bit with_stall, input bit with_pause);
      for (int n = 0; n < count; n++) pair_queue.push_back({random_sample(), random_sample()});
      if (with_stall || with_pause)
         while (pair_queue.size() > count / 2) @(posedge clock);
      // Hold off the receiver so the block backs up into the input
      if (with_stall) begin
         stall_kick <= 1'b1;
         @(posedge clock);
         stall_kick <= 1'b0;
      end
      // Pause the sender until the block has answered everything
      if (with_pause) begin
         send_hold <= 1'b1;
         @(posedge clock);
         while (req_tvalid || echo_expected.size() != 0) @(posedge clock);
         send_hold <= 1'b0;
      end
      drain_all();
   endtask

   initial begin
      logic [47:0] corner_beats [10];
      corner_beats = '{{24'h0, 24'h0}, {FULL_POS, FULL_POS}, {FULL_NEG, FULL_NEG},
                       {FULL_POS, FULL_NEG}, {FULL_NEG, FULL_POS}, {MINUS_ONE, PLUS_ONE},
                       {PLUS_ONE, MINUS_ONE}, {24'h555555, 24'hAAAAAA},
                       {24'hAAAAAA, 24'h555555}, {24'h0, 24'h0}};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Corner pairs under the reset settings
      foreach (corner_beats[k]) pair_queue.push_back(corner_beats[k]);
      drain_all();

      // Shortest taps, full gains: drive the loop and outputs into saturation
      apply_setting(0, 3, 65536, 131072, 32440, 0, 65536, 0);
      foreach (corner_beats[k]) pair_queue.push_back(corner_beats[k]);
      repeat (4) pair_queue.push_back({FULL_POS, FULL_POS});
      drain_all();

      // Receiver idles more than sender
      apply_setting(5, 9, 40000, 65536, 30000, 60000, -32768, 65536);
      run_block(80, 1'b1, 1'b0);
      random_setting();
      run_block(80, 1'b0, 1'b0);
      apply_setting(32767, 32766, 131071, 262143, 32767, 65535, 131072, 131071);
      run_block(80, 1'b0, 1'b0);

      // Sender idles more than receiver
      send_idle_pct <= 61;
      recv_idle_pct <= 38;
      apply_setting(4, 32767, 0, 0, 0, 0, 0, 0);
      run_block(60, 1'b0, 1'b1);
      random_setting();
      run_block(80, 1'b0, 1'b0);
      random_setting();
      run_block(80, 1'b0, 1'b0);

      // No idling on either side
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      random_setting();
      run_block(80, 1'b1, 1'b0);
      random_setting();
      run_block(80, 1'b0, 1'b0);
      apply_setting(sfdt_pkg::DELAY_LEFT_RST, sfdt_pkg::DELAY_RIGHT_RST,
                    sfdt_pkg::WET_GAIN_RST, sfdt_pkg::DRY_GAIN_RST,
                    sfdt_pkg::FEEDBACK_GAIN_RST, sfdt_pkg::LOWPASS_COEF_RST,
                    sfdt_pkg::LOW_MIX_RST, sfdt_pkg::HIGH_MIX_RST);
      run_block(80, 1'b0, 1'b0);

      if (fail_count == 0 && echo_expected.size() == 0) begin
         $display("stereo_feedback_delay_tone verification clean");
      end else begin
         $display("stereo_feedback_delay_tone verification failed");
      end
      $finish;
   end

endmodule
